### hw/rtl/mlp_inference_4_7_7_1_core_macros.svh
// Assertion helpers shared by the RTL of the inference core.
// Each check samples on i_clk and is off while i_rst_n is low.
`ifndef MLP_INFERENCE_4_7_7_1_CORE_MACROS_SVH
`define MLP_INFERENCE_4_7_7_1_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define MLPI_CHECK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define MLPI_CHECK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MLPI_CHECK(lbl, prop, msg)
`define MLPI_CHECK_NEXT(lbl, ante, cons, msg)
`endif
`endif

### hw/rtl/mlpi_pkg.sv
package mlpi_pkg;

    localparam int DATA_W = 16;
    localparam int PROD_W = 2 * DATA_W;

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_INFER = 1'b1;

    typedef enum logic [1:0] {
        LAYER_ONE,
        LAYER_TWO,
        LAYER_OUT
    } t_layer;

    // One MAC slot handed from the sequencer to the datapath
    typedef struct packed {
        logic                       valid;
        t_layer                     layer;
        logic                       first;
        logic                       last;
        logic signed [DATA_W-1:0]   feat;
    } t_issue;

    function automatic int param_total(input int n_in, input int h1, input int h2);
        return n_in * h1 + h1 + h1 * h2 + h2 + h2 + 1;
    endfunction

    function automatic int param_aw(input int n_in, input int h1, input int h2);
        return $clog2(param_total(n_in, h1, h2));
    endfunction

    function automatic int act_aw(input int h1, input int h2);
        return $clog2(h1 + h2);
    endfunction

endpackage

### hw/rtl/mlpi_ram.sv
module mlpi_ram
    import mlpi_pkg::*;
#(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/mlpi_seq.sv
`include "mlp_inference_4_7_7_1_core_macros.svh"

module mlpi_seq
    import mlpi_pkg::*;
#(
    parameter int INPUT_COUNT = 4,
    parameter int HIDDEN_ONE  = 7,
    parameter int HIDDEN_TWO  = 7
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_go,
    input  logic signed [DATA_W-1:0] i_feature_a,
    input  logic signed [DATA_W-1:0] i_feature_b,
    input  logic signed [DATA_W-1:0] i_feature_c,
    input  logic signed [DATA_W-1:0] i_feature_d,
    input  logic                     i_pipe_busy,
    output logic                     o_busy,
    output t_issue                   o_issue,
    output logic [param_aw(INPUT_COUNT, HIDDEN_ONE, HIDDEN_TWO)-1:0] o_param_raddr,
    output logic [act_aw(HIDDEN_ONE, HIDDEN_TWO)-1:0]                o_act_raddr,
    output logic [act_aw(HIDDEN_ONE, HIDDEN_TWO)-1:0]                o_act_waddr
);

    localparam int PW      = param_aw(INPUT_COUNT, HIDDEN_ONE, HIDDEN_TWO);
    localparam int AAW     = act_aw(HIDDEN_ONE, HIDDEN_TWO);
    localparam int MAX_HID = (HIDDEN_ONE > HIDDEN_TWO) ? HIDDEN_ONE : HIDDEN_TWO;
    localparam int MAX_IN  = (INPUT_COUNT > MAX_HID) ? INPUT_COUNT : MAX_HID;
    localparam int CW      = $clog2(MAX_IN + 1);
    localparam int JW      = $clog2(MAX_HID + 1);

    localparam int W1_BASE = 0;
    localparam int B1_BASE = W1_BASE + INPUT_COUNT * HIDDEN_ONE;
    localparam int W2_BASE = B1_BASE + HIDDEN_ONE;
    localparam int B2_BASE = W2_BASE + HIDDEN_ONE * HIDDEN_TWO;
    localparam int W3_BASE = B2_BASE + HIDDEN_TWO;
    localparam int B3_BASE = W3_BASE + HIDDEN_TWO;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ISSUE,
        S_DRAIN,
        S_FLUSH
    } t_state;

    t_state                   r_state;
    t_layer                   r_layer;
    logic [CW-1:0]            r_i;
    logic [JW-1:0]            r_j;
    logic signed [DATA_W-1:0] r_feat [4];

    logic [CW-1:0]            w_n_in;
    logic [JW-1:0]            w_last_j;
    logic                     w_bias;
    int                       w_paddr;
    int                       w_araddr;
    int                       w_awaddr;
    logic signed [DATA_W-1:0] w_feat;

    always_comb begin
        unique case (r_layer)
            LAYER_ONE: begin
                w_n_in   = CW'(INPUT_COUNT);
                w_last_j = JW'(HIDDEN_ONE - 1);
            end
            LAYER_TWO: begin
                w_n_in   = CW'(HIDDEN_ONE);
                w_last_j = JW'(HIDDEN_TWO - 1);
            end
            default: begin
                w_n_in   = CW'(HIDDEN_TWO);
                w_last_j = '0;
            end
        endcase
    end

    assign w_bias = (r_i == w_n_in);

    always_comb begin
        unique case (r_layer)
            LAYER_ONE: begin
                w_paddr  = w_bias ? (B1_BASE + int'(r_j))
                                  : (W1_BASE + int'(r_i) * HIDDEN_ONE + int'(r_j));
                w_araddr = 0;
                w_awaddr = int'(r_j);
            end
            LAYER_TWO: begin
                w_paddr  = w_bias ? (B2_BASE + int'(r_j))
                                  : (W2_BASE + int'(r_i) * HIDDEN_TWO + int'(r_j));
                w_araddr = int'(r_i);
                w_awaddr = HIDDEN_ONE + int'(r_j);
            end
            default: begin
                w_paddr  = w_bias ? B3_BASE : (W3_BASE + int'(r_i));
                w_araddr = HIDDEN_ONE + int'(r_i);
                w_awaddr = 0;
            end
        endcase
    end

    // inputs past the fourth read as zero
    assign w_feat = (int'(r_i) < 4) ? r_feat[2'(r_i)] : '0;

    assign o_param_raddr = PW'(w_paddr);
    assign o_act_raddr   = AAW'(w_araddr);
    assign o_act_waddr   = AAW'(w_awaddr);

    assign o_issue.valid = (r_state == S_ISSUE);
    assign o_issue.layer = r_layer;
    assign o_issue.first = (r_i == '0);
    assign o_issue.last  = w_bias;
    assign o_issue.feat  = w_feat;

    assign o_busy = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_feat[0] <= i_feature_a;
            r_feat[1] <= i_feature_b;
            r_feat[2] <= i_feature_c;
            r_feat[3] <= i_feature_d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_layer <= LAYER_ONE;
            r_i     <= '0;
            r_j     <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_go) begin
                        r_state <= S_ISSUE;
                        r_layer <= LAYER_ONE;
                        r_i     <= '0;
                        r_j     <= '0;
                    end
                end
                S_ISSUE: begin
                    if (w_bias) begin
                        r_i <= '0;
                        if (r_j == w_last_j) begin
                            r_j <= '0;
                            // hold until the layer's last neuron is written back
                            unique case (r_layer)
                                LAYER_ONE: begin
                                    r_layer <= LAYER_TWO;
                                    r_state <= S_DRAIN;
                                end
                                LAYER_TWO: begin
                                    r_layer <= LAYER_OUT;
                                    r_state <= S_DRAIN;
                                end
                                default: begin
                                    r_state <= S_FLUSH;
                                end
                            endcase
                        end else begin
                            r_j <= r_j + 1'b1;
                        end
                    end else begin
                        r_i <= r_i + 1'b1;
                    end
                end
                S_DRAIN: begin
                    if (!i_pipe_busy) begin
                        r_state <= S_ISSUE;
                    end
                end
                S_FLUSH: begin
                    if (!i_pipe_busy) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `MLPI_CHECK_NEXT(a_go_starts, i_go, r_state == S_ISSUE, "inference did not start issuing")
    `MLPI_CHECK(a_resume_empty, ($past(r_state == S_DRAIN) && r_state == S_ISSUE) |-> !$past(i_pipe_busy), "layer resumed before write back")
    `MLPI_CHECK(a_index_range, r_i <= w_n_in, "input index past bias slot")

endmodule

### hw/rtl/mlpi_mac.sv
`include "mlp_inference_4_7_7_1_core_macros.svh"

module mlpi_mac
    import mlpi_pkg::*;
#(
    parameter int INPUT_COUNT   = 4,
    parameter int HIDDEN_ONE    = 7,
    parameter int HIDDEN_TWO    = 7,
    parameter int FRACTION_BITS = 12
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_clear,
    input  t_issue                   i_issue,
    input  logic [act_aw(HIDDEN_ONE, HIDDEN_TWO)-1:0] i_act_waddr,
    input  logic signed [DATA_W-1:0] i_weight,
    input  logic signed [DATA_W-1:0] i_act_rdata,
    output logic                     o_pipe_busy,
    output logic                     o_act_we,
    output logic [act_aw(HIDDEN_ONE, HIDDEN_TWO)-1:0] o_act_waddr,
    output logic [DATA_W-1:0]        o_act_wdata,
    output logic                     o_valid,
    output logic signed [DATA_W-1:0] o_prediction,
    output logic                     o_saturated
);

    localparam int AAW     = act_aw(HIDDEN_ONE, HIDDEN_TWO);
    localparam int MAX_HID = (HIDDEN_ONE > HIDDEN_TWO) ? HIDDEN_ONE : HIDDEN_TWO;
    localparam int MAX_IN  = (INPUT_COUNT > MAX_HID) ? INPUT_COUNT : MAX_HID;
    localparam int ACC_W   = PROD_W + $clog2(MAX_IN + 1) + 1;

    localparam logic signed [DATA_W-1:0] ONE   = DATA_W'(1 << FRACTION_BITS);
    localparam logic signed [ACC_W-1:0]  HALF  = ACC_W'(1 << (FRACTION_BITS - 1));
    localparam logic signed [ACC_W-1:0]  Y_MAX = ACC_W'(32767);
    localparam logic signed [ACC_W-1:0]  Y_MIN = ACC_W'(-32768);

    t_issue                   r_s1;
    logic [AAW-1:0]           r_s1_waddr;

    logic                     r_s2_valid;
    logic                     r_s2_first;
    logic                     r_s2_last;
    t_layer                   r_s2_layer;
    logic [AAW-1:0]           r_s2_waddr;
    logic signed [PROD_W-1:0] r_prod;

    logic                     r_s3_done;
    t_layer                   r_s3_layer;
    logic [AAW-1:0]           r_s3_waddr;
    logic signed [ACC_W-1:0]  r_acc;

    logic                     r_sat;
    logic                     r_valid;
    logic signed [DATA_W-1:0] r_pred;
    logic                     r_pred_sat;

    logic signed [DATA_W-1:0] w_opnd;
    logic signed [PROD_W-1:0] n_prod;
    logic signed [ACC_W-1:0]  n_acc;
    logic signed [ACC_W-1:0]  w_shift;
    logic signed [DATA_W-1:0] w_y;
    logic                     w_clip;
    logic                     w_final;

    // bias slot multiplies by one in Q format, so it lands pre-shifted
    always_comb begin
        if (r_s1.last) begin
            w_opnd = ONE;
        end else if (r_s1.layer == LAYER_ONE) begin
            w_opnd = r_s1.feat;
        end else begin
            w_opnd = i_act_rdata;
        end
    end

    assign n_prod = PROD_W'(i_weight) * PROD_W'(w_opnd);
    assign n_acc  = (r_s2_first ? '0 : r_acc) + ACC_W'(r_prod);

    // round half up, then floor shift
    assign w_shift = (r_acc + HALF) >>> FRACTION_BITS;

    always_comb begin
        if (w_shift > Y_MAX) begin
            w_y    = DATA_W'(32767);
            w_clip = 1'b1;
        end else if (w_shift < Y_MIN) begin
            w_y    = DATA_W'(-32768);
            w_clip = 1'b1;
        end else begin
            w_y    = DATA_W'(w_shift);
            w_clip = 1'b0;
        end
    end

    assign w_final     = r_s3_done && (r_s3_layer == LAYER_OUT);
    assign o_act_we    = r_s3_done && (r_s3_layer != LAYER_OUT);
    assign o_act_waddr = r_s3_waddr;
    assign o_act_wdata = w_y[DATA_W-1] ? '0 : w_y;
    assign o_pipe_busy = r_s1.valid || r_s2_valid || r_s3_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1       <= '0;
            r_s2_valid <= 1'b0;
            r_s3_done  <= 1'b0;
            r_sat      <= 1'b0;
            r_valid    <= 1'b0;
        end else begin
            r_s1       <= i_issue;
            r_s2_valid <= r_s1.valid;
            r_s3_done  <= r_s2_valid && r_s2_last;
            r_valid    <= w_final;
            if (i_clear) begin
                r_sat <= 1'b0;
            end else if (r_s3_done && w_clip) begin
                r_sat <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_waddr <= i_act_waddr;
        r_s2_first <= r_s1.first;
        r_s2_last  <= r_s1.last;
        r_s2_layer <= r_s1.layer;
        r_s2_waddr <= r_s1_waddr;
        r_prod     <= n_prod;
        r_s3_layer <= r_s2_layer;
        r_s3_waddr <= r_s2_waddr;
        if (r_s2_valid) begin
            r_acc <= n_acc;
        end
        if (w_final) begin
            r_pred     <= w_y;
            r_pred_sat <= r_sat || w_clip;
        end
    end

    assign o_valid      = r_valid;
    assign o_prediction = r_pred;
    assign o_saturated  = r_pred_sat;

    `MLPI_CHECK(a_finish_spacing, r_s3_done |-> !$past(r_s3_done), "two neuron finishes back to back")
    `MLPI_CHECK_NEXT(a_one_result, o_valid, !o_valid, "result strobe longer than one cycle")

endmodule

### hw/rtl/mlp_inference_4_7_7_1_core.sv
// Fixed-point MLP inference core: INPUT_COUNT inputs, two ReLU hidden layers of
// HIDDEN_ONE and HIDDEN_TWO neurons, one linear output, all values signed Q3.12.
// Command channel: an item is taken at a clock edge with start high and busy low.
//   i_mode = write: i_param_value goes to parameter word i_param_index (w1, b1,
//   w2, b2, w3, b3 packed in order); indexes past the store are dropped. Busy
//   stays low, no result.
//   i_mode = infer: features are captured and busy rises until the result.
// Result channel: o_valid pulses for one cycle with o_prediction and
// o_saturated; the receiver cannot stall it, so it must take it then.
// Timing: one shared multiply-accumulate issues one parameter-memory read per
// cycle, HIDDEN_ONE*(INPUT_COUNT+1) + HIDDEN_TWO*(HIDDEN_ONE+1) + HIDDEN_TWO + 1
// slots (99 here), except that each of the two layer boundaries stalls issue
// until the last hidden value is written back. The next item can be taken
// once busy falls after the strobe.
// Reset clears control only; parameter words are undefined until written.
module mlp_inference_4_7_7_1_core
    import mlpi_pkg::*;
#(
    parameter int INPUT_COUNT   = 4,
    parameter int HIDDEN_ONE    = 7,
    parameter int HIDDEN_TWO    = 7,
    parameter int FRACTION_BITS = 12
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic                     i_mode,
    input  logic [6:0]               i_param_index,
    input  logic signed [DATA_W-1:0] i_param_value,
    input  logic signed [DATA_W-1:0] i_feature_a,
    input  logic signed [DATA_W-1:0] i_feature_b,
    input  logic signed [DATA_W-1:0] i_feature_c,
    input  logic signed [DATA_W-1:0] i_feature_d,
    output logic                     o_valid,
    output logic signed [DATA_W-1:0] o_prediction,
    output logic                     o_saturated
);

    localparam int PT  = param_total(INPUT_COUNT, HIDDEN_ONE, HIDDEN_TWO);
    localparam int PW  = param_aw(INPUT_COUNT, HIDDEN_ONE, HIDDEN_TWO);
    localparam int AAW = act_aw(HIDDEN_ONE, HIDDEN_TWO);

    logic                     w_accept;
    logic                     w_go;
    logic                     w_pwe;
    logic [31:0]              w_pidx;
    t_issue                   w_issue;
    logic [PW-1:0]            w_praddr;
    logic [AAW-1:0]           w_araddr;
    logic [AAW-1:0]           w_issue_waddr;
    logic                     w_pipe_busy;
    logic [DATA_W-1:0]        w_weight;
    logic [DATA_W-1:0]        w_act_rdata;
    logic                     w_act_we;
    logic [AAW-1:0]           w_act_waddr;
    logic [DATA_W-1:0]        w_act_wdata;

    assign w_accept = start && !busy;
    assign w_go     = w_accept && (i_mode == MODE_INFER);
    assign w_pidx   = 32'(i_param_index);
    assign w_pwe    = w_accept && (i_mode == MODE_WRITE) && (w_pidx < 32'(PT));

    mlpi_ram #(
        .WIDTH (DATA_W),
        .DEPTH (PT)
    ) u_param_ram (
        .i_clk   (i_clk),
        .i_we    (w_pwe),
        .i_waddr (w_pidx[PW-1:0]),
        .i_wdata (i_param_value),
        .i_raddr (w_praddr),
        .o_rdata (w_weight)
    );

    mlpi_ram #(
        .WIDTH (DATA_W),
        .DEPTH (HIDDEN_ONE + HIDDEN_TWO)
    ) u_act_ram (
        .i_clk   (i_clk),
        .i_we    (w_act_we),
        .i_waddr (w_act_waddr),
        .i_wdata (w_act_wdata),
        .i_raddr (w_araddr),
        .o_rdata (w_act_rdata)
    );

    mlpi_seq #(
        .INPUT_COUNT (INPUT_COUNT),
        .HIDDEN_ONE  (HIDDEN_ONE),
        .HIDDEN_TWO  (HIDDEN_TWO)
    ) u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_go          (w_go),
        .i_feature_a   (i_feature_a),
        .i_feature_b   (i_feature_b),
        .i_feature_c   (i_feature_c),
        .i_feature_d   (i_feature_d),
        .i_pipe_busy   (w_pipe_busy),
        .o_busy        (busy),
        .o_issue       (w_issue),
        .o_param_raddr (w_praddr),
        .o_act_raddr   (w_araddr),
        .o_act_waddr   (w_issue_waddr)
    );

    mlpi_mac #(
        .INPUT_COUNT   (INPUT_COUNT),
        .HIDDEN_ONE    (HIDDEN_ONE),
        .HIDDEN_TWO    (HIDDEN_TWO),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_mac (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_clear      (w_go),
        .i_issue      (w_issue),
        .i_act_waddr  (w_issue_waddr),
        .i_weight     (w_weight),
        .i_act_rdata  (w_act_rdata),
        .o_pipe_busy  (w_pipe_busy),
        .o_act_we     (w_act_we),
        .o_act_waddr  (w_act_waddr),
        .o_act_wdata  (w_act_wdata),
        .o_valid      (o_valid),
        .o_prediction (o_prediction),
        .o_saturated  (o_saturated)
    );

endmodule
